// ----- rtl/core/madl_pkg.sv -----
`default_nettype none

package madl_pkg;

  // channel and window geometry
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned CH_W        = $clog2(CHANNELS);
  localparam int unsigned MAX_WINDOW  = 32;
  localparam int unsigned SLOT_W      = $clog2(MAX_WINDOW);
  localparam int unsigned WIN_W       = 6;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned THR_W       = 10;
  localparam int unsigned SUM_W       = SLOT_W + SAMPLE_BITS;
  localparam int unsigned PROD_W      = THR_W + WIN_W;
  localparam int unsigned MASK_W      = 16;

  // sample ring store, one row of MAX_WINDOW slots per channel
  localparam int unsigned STORE_DEPTH = CHANNELS * MAX_WINDOW;
  localparam int unsigned STORE_AW    = CH_W + SLOT_W;

  // stream packing
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;
  localparam logic [WIN_W-1:0]     WINDOW_RST     = 6'd20;
  localparam logic [THR_W-1:0]     THRESHOLD_RST  = 10'd34;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic              scan_done;
    logic [MASK_W-1:0] line_mask;
    logic              line_bit;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/madl_ram.sv -----
`default_nettype none

module madl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/multichannel_average_line_detector.sv -----
`default_nettype none

// Moving-average line detector over sixteen multiplexed sensor channels. Each
// request carries one converter sample and its channel; each channel keeps a
// ring of its last window_len samples in a 512-entry sample memory and a running
// sum in a 16-entry sum memory. A channel's detection bit is set when
// sum >= threshold * count, where count is the number of samples held (it grows
// during warm-up up to the clamped window). One result per request, in order,
// with the channel bit, the mask of all channels and a scan-done flag on
// channel 15. Throughput is one request per cycle while the queue has room: the
// sample memory is read and written at one slot in the accept cycle, and the sum
// read-modify-write completes in the next cycle, forwarding for back-to-back
// requests on one channel. Results pass the update register into a four-entry
// queue that absorbs output stalls. Writing window_len clears the per-channel
// counters and sums at once; configure only while no request is in flight.

module multichannel_average_line_detector
  import madl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // sample stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // channel[3:0], sample[13:4], zero
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // line_bit[0], line_mask[16:1], zero
  output logic                        m_axis_tlast,  // scan_done
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // configuration registers
  logic [WIN_W-1:0] wlen_q;
  logic [THR_W-1:0] thr_q;
  logic [WIN_W-1:0] eff_w;

  // per-channel ring position and fill count
  logic [SLOT_W-1:0] slot_q [CHANNELS];
  logic [WIN_W-1:0]  fill_q [CHANNELS];
  logic [CHANNELS-1:0] sum_vld_q;
  logic [MASK_W-1:0]   mask_q;
  logic [MASK_W-1:0]   mask_d;

  // accept stage
  logic                   in_fire;
  logic [CH_W-1:0]        a_ch;
  logic [SAMPLE_BITS-1:0] a_smp;
  logic [SLOT_W-1:0]      a_slot;
  logic [SLOT_W-1:0]      a_slot_next;
  logic [WIN_W-1:0]       a_fill;
  logic                   a_full;
  logic [WIN_W-1:0]       a_fill_new;

  // update stage
  logic                   b_valid_q;
  logic [CH_W-1:0]        b_ch_q;
  logic [SAMPLE_BITS-1:0] b_smp_q;
  logic                   b_full_q;
  logic [WIN_W-1:0]       b_fill_q;
  logic                   b_fwd_q;
  logic [SUM_W-1:0]       b_fwd_sum_q;
  logic [SUM_W-1:0]       b_sum_old;
  logic [SUM_W-1:0]       b_sum_new;
  logic [SUM_W:0]         b_sum_wide;
  logic [PROD_W-1:0]      b_prod;
  logic                   b_bit;
  result_t                b_res;

  // memory read data
  logic [SAMPLE_BITS-1:0] store_rdata;
  logic [SUM_W-1:0]       sum_rdata;

  // result queue
  result_t            fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               pop;
  result_t            out_res;

  // effective window: zero acts as one, clamp to the ring size
  always_comb begin
    if (wlen_q == '0) begin
      eff_w = WIN_W'(1);
    end else if (wlen_q > WIN_W'(MAX_WINDOW)) begin
      eff_w = WIN_W'(MAX_WINDOW);
    end else begin
      eff_w = wlen_q;
    end
  end

  // accept stage decode
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign a_ch    = s_axis_tdata[CH_W-1:0];
  assign a_smp   = s_axis_tdata[CH_W+SAMPLE_BITS-1:CH_W];

  always_comb begin
    a_slot     = slot_q[a_ch];
    a_fill     = fill_q[a_ch];
    a_full     = a_fill >= eff_w;
    a_fill_new = a_full ? a_fill : a_fill + WIN_W'(1);
    if ((WIN_W'(a_slot) + WIN_W'(1)) >= eff_w) begin
      a_slot_next = '0;
    end else begin
      a_slot_next = a_slot + SLOT_W'(1);
    end
  end

  // room for the request in flight plus the queue
  assign s_axis_tready = (cnt_q + FIFO_CW'(b_valid_q)) < FIFO_CW'(FIFO_DEPTH);

  // sample ring: read the oldest sample and overwrite it in the same cycle
  madl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i ({a_ch, a_slot}),
    .wdata_i (a_smp),
    .re_i    (in_fire),
    .raddr_i ({a_ch, a_slot}),
    .rdata_o (store_rdata)
  );

  // running sums
  madl_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sum (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_ch_q),
    .wdata_i (b_sum_new),
    .re_i    (in_fire),
    .raddr_i (a_ch),
    .rdata_o (sum_rdata)
  );

  // sum update, forwarding when the previous request wrote the same channel
  always_comb begin
    if (b_fwd_q) begin
      b_sum_old = b_fwd_sum_q;
    end else if (sum_vld_q[b_ch_q]) begin
      b_sum_old = sum_rdata;
    end else begin
      b_sum_old = '0;
    end
    b_sum_wide = {1'b0, b_sum_old} + (SUM_W + 1)'(b_smp_q)
                 - (b_full_q ? (SUM_W + 1)'(store_rdata) : '0);
    b_sum_new  = b_sum_wide[SUM_W-1:0];
    b_prod     = PROD_W'(thr_q) * PROD_W'(b_fill_q);
    b_bit      = PROD_W'(b_sum_new) >= b_prod;
  end

  // mask update and result word
  always_comb begin
    mask_d = mask_q;
    if (b_valid_q) begin
      mask_d[b_ch_q] = b_bit;
    end
    b_res.line_bit  = b_bit;
    b_res.line_mask = mask_d;
    b_res.scan_done = b_ch_q == CH_W'(CHANNELS - 1);
  end

  // configuration and per-channel counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= WINDOW_RST;
      thr_q     <= THRESHOLD_RST;
      sum_vld_q <= '0;
      mask_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        slot_q[a_ch] <= a_slot_next;
        fill_q[a_ch] <= a_fill_new;
      end
      if (b_valid_q) begin
        sum_vld_q[b_ch_q] <= 1'b1;
      end
      mask_q <= mask_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WINDOW_LEN: begin
            wlen_q    <= cfg_wdata_i[WIN_W-1:0];
            sum_vld_q <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
              slot_q[i] <= '0;
              fill_q[i] <= '0;
            end
          end
          REG_THRESHOLD: begin
            thr_q <= cfg_wdata_i[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_fwd_q   <= 1'b0;
    end else begin
      b_valid_q <= in_fire;
      b_fwd_q   <= in_fire && b_valid_q && (b_ch_q == a_ch);
    end
  end

  // update stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_ch_q      <= a_ch;
      b_smp_q     <= a_smp;
      b_full_q    <= a_full;
      b_fill_q    <= a_fill_new;
      b_fwd_sum_q <= b_sum_new;
    end
  end

  // result queue
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (b_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + FIFO_CW'(b_valid_q) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      fifo_q[wr_ptr_q] <= b_res;
    end
  end

  // output stream
  assign out_res       = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {(OUT_TDATA_W - MASK_W - 1)'(0), out_res.line_mask, out_res.line_bit};
  assign m_axis_tlast  = out_res.scan_done;

  // queue never overflows: the accept credit covers the request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (cnt_q < FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // back-to-back requests on one channel take the forwarded sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && b_valid_q && (b_ch_q == a_ch)) |=> b_fwd_q)
    else $error("missing sum forward");

  // a window write restarts every channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_WINDOW_LEN) && !b_valid_q) |=> (sum_vld_q == '0))
    else $error("window write left stale sums");

  // an accepted request passes the update stage before it reaches the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !pop && !b_valid_q) |=> (cnt_q == $past(cnt_q)))
    else $error("queue count slipped");

endmodule

`default_nettype wire
